### hw/rtl/multichannel_rms_level_meter_defines.svh
// Assertion helpers for the level meter RTL.
`ifndef MULTICHANNEL_RMS_LEVEL_METER_DEFINES_SVH
`define MULTICHANNEL_RMS_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define MLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/mlm_pkg.sv
package mlm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 24;

    // Fixed datapath widths
    localparam int SUM_W      = 62;  // per-channel sum of squares
    localparam int WIN_W      = 16;  // window length
    localparam int CC_W       = 4;   // channel count register
    localparam int REM_W      = 33;  // partial remainder of the shared unit
    localparam int STEP_W     = 6;   // iteration counter
    localparam int DIV_STEPS  = 62;  // one quotient bit per step
    localparam int SQRT_STEPS = 31;  // one root bit per step

    // Configuration port
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_WINDOW_FRAMES = 1'b1;
    localparam logic [CC_W-1:0]  CC_RESET  = 4'd2;
    localparam logic [WIN_W-1:0] WIN_RESET = 16'd512;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_SUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_OUT
    } t_state;

endpackage

### hw/rtl/multichannel_rms_level_meter.sv
// Multichannel RMS level meter. Interleaved signed Q1.23 samples enter one
// item at a time on i_sample; the channel of each item follows a rotating
// position (channel 0 first after reset, after each level and after any
// register write). Each item is accepted and squared while idle and added into
// its channel's 62-bit accumulator before the next one is taken. The item that
// closes the last frame of a window starts the level computation, during which
// o_ready stays low: for each active channel one shared shift-and-subtract unit
// divides the sum by the window length and takes the floor square root; the
// saturated RMS values are summed and divided by the channel count, and the
// level leaves through an output register. The shared unit yields one result
// bit per cycle. A finished level waits in the output register while new items
// are taken; the next level is held back until it has been taken. Registers:
// address 0 holds the channel count (0 acts as 1, above the channel maximum it
// saturates), address 4 the window length in frames (0 acts as 1). Writing
// either one restarts the window; write only while no item is in flight.
module multichannel_rms_level_meter #(
    parameter int MAX_CHANNELS = mlm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mlm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // level output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_BITS-2:0]      o_level,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlm_pkg::ADDR_W-1:0]  paddr,
    input  logic [mlm_pkg::APB_W-1:0]   pwdata,
    output logic [mlm_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);

`include "multichannel_rms_level_meter_defines.svh"

    localparam int SQ_W = 2 * SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_CHANNELS + 1);        // holds channel count
    localparam int CNT  = CW + 1;                          // compare width
    localparam int PW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TW   = SAMPLE_BITS - 1 + PW;            // sum of channel RMS
    localparam logic [mlm_pkg::SUM_W-1:0] FULL_SCALE =
        (mlm_pkg::SUM_W'(1) << (SAMPLE_BITS - 1)) - mlm_pkg::SUM_W'(1);

    mlm_pkg::t_state             r_state;
    mlm_pkg::t_state             n_state;

    logic [mlm_pkg::CC_W-1:0]    r_cc;
    logic [mlm_pkg::WIN_W-1:0]   r_win;
    logic [PW-1:0]               r_pos;
    logic [mlm_pkg::WIN_W-1:0]   r_frame;
    logic [mlm_pkg::SUM_W-1:0]   r_acc [MAX_CHANNELS];
    logic [mlm_pkg::SUM_W-1:0]   r_square;
    logic [TW-1:0]               r_total;
    logic [SAMPLE_BITS-2:0]      r_level;
    logic                        r_out_valid;

    logic signed [SQ_W-1:0]      w_prod;
    logic [CW-1:0]               w_chans;
    logic [mlm_pkg::WIN_W-1:0]   w_win;
    logic [PW-1:0]               w_pos;
    logic                        w_last_chan;
    logic                        w_last_frame;
    logic                        w_out_free;
    logic                        w_cfg_wr;
    logic [mlm_pkg::SUM_W-1:0]   w_rms;

    mlm_pkg::t_unit_cmd          w_cmd;
    logic [mlm_pkg::SUM_W-1:0]   w_unit_x;
    logic [mlm_pkg::WIN_W-1:0]   w_unit_d;
    logic                        w_unit_done;
    logic [mlm_pkg::SUM_W-1:0]   w_unit_q;

    // ---------------------------------------------------------------
    // Effective configuration and position bookkeeping
    // ---------------------------------------------------------------
    always_comb begin
        if (r_cc == '0) begin
            w_chans = CW'(1);
        end else if ({1'b0, r_cc} > (mlm_pkg::CC_W + 1)'(MAX_CHANNELS)) begin
            w_chans = CW'(MAX_CHANNELS);
        end else begin
            w_chans = CW'(r_cc);
        end
    end

    assign w_win = (r_win == '0) ? mlm_pkg::WIN_W'(1) : r_win;

    // Wrap a stale position back to channel 0
    assign w_pos        = (CNT'(r_pos) >= CNT'(w_chans)) ? '0 : r_pos;
    assign w_last_chan  = (CNT'(w_pos) + CNT'(1)) == CNT'(w_chans);
    assign w_last_frame = (r_frame + 1'b1) == w_win;
    assign w_out_free   = ~r_out_valid | i_ready;
    assign w_cfg_wr     = psel & penable & pwrite & pready;

    // Square the signed sample directly; the result is never negative
    assign w_prod = i_sample * i_sample;

    // Clamp the root to full scale
    assign w_rms = (w_unit_q > FULL_SCALE) ? FULL_SCALE : w_unit_q;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlm_pkg::S_IDLE: begin
                if (i_valid) n_state = mlm_pkg::S_ACC;
            end
            mlm_pkg::S_ACC: begin
                n_state = (w_last_chan && w_last_frame) ?
                          mlm_pkg::S_DIV_GO : mlm_pkg::S_IDLE;
            end
            mlm_pkg::S_DIV_GO:    n_state = mlm_pkg::S_DIV_WAIT;
            mlm_pkg::S_DIV_WAIT: begin
                if (w_unit_done) n_state = mlm_pkg::S_SQRT_GO;
            end
            mlm_pkg::S_SQRT_GO:   n_state = mlm_pkg::S_SQRT_WAIT;
            mlm_pkg::S_SQRT_WAIT: begin
                if (w_unit_done) n_state = mlm_pkg::S_SUM;
            end
            mlm_pkg::S_SUM: begin
                n_state = w_last_chan ? mlm_pkg::S_MEAN_GO : mlm_pkg::S_DIV_GO;
            end
            mlm_pkg::S_MEAN_GO:   n_state = mlm_pkg::S_MEAN_WAIT;
            mlm_pkg::S_MEAN_WAIT: begin
                if (w_unit_done) n_state = mlm_pkg::S_OUT;
            end
            mlm_pkg::S_OUT: begin
                if (w_out_free) n_state = mlm_pkg::S_IDLE;
            end
            default: n_state = mlm_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs and shared unit operands
    // ---------------------------------------------------------------
    always_comb begin
        o_ready     = 1'b0;
        w_cmd.start = 1'b0;
        w_cmd.op    = mlm_pkg::OP_DIV;
        w_unit_x    = r_acc[w_pos];
        w_unit_d    = w_win;
        case (r_state)
            mlm_pkg::S_IDLE: o_ready = 1'b1;
            mlm_pkg::S_DIV_GO: begin
                // sum / window
                w_cmd.start = 1'b1;
            end
            mlm_pkg::S_SQRT_GO: begin
                // root of the quotient just produced
                w_cmd.start = 1'b1;
                w_cmd.op    = mlm_pkg::OP_SQRT;
                w_unit_x    = w_unit_q;
            end
            mlm_pkg::S_MEAN_GO: begin
                // total / channels
                w_cmd.start = 1'b1;
                w_unit_x    = mlm_pkg::SUM_W'(r_total);
                w_unit_d    = mlm_pkg::WIN_W'(w_chans);
            end
            default: ;
        endcase
    end

    mlm_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_x     (w_unit_x),
        .i_d     (w_unit_d),
        .o_done  (w_unit_done),
        .o_q     (w_unit_q)
    );

    // ---------------------------------------------------------------
    // Control state, accumulators and registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlm_pkg::S_IDLE;
            r_cc        <= mlm_pkg::CC_RESET;
            r_win       <= mlm_pkg::WIN_RESET;
            r_pos       <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Load a new level or drop the one just taken
            if ((r_state == mlm_pkg::S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                mlm_pkg::S_ACC: begin
                    // add the square, then advance channel and frame
                    r_acc[w_pos] <= r_acc[w_pos] + r_square;
                    if (w_last_chan) begin
                        r_pos   <= '0;
                        r_frame <= w_last_frame ? '0 : r_frame + 1'b1;
                    end else begin
                        r_pos <= w_pos + 1'b1;
                    end
                end
                mlm_pkg::S_SUM: begin
                    // r_pos walks the channels during the window end
                    r_pos <= w_last_chan ? '0 : w_pos + 1'b1;
                end
                mlm_pkg::S_OUT: begin
                    if (w_out_free) begin
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                            r_acc[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase

            // Any register write restarts the window
            if (w_cfg_wr) begin
                if (paddr[mlm_pkg::ADDR_W-1] == mlm_pkg::REG_WINDOW_FRAMES) begin
                    r_win <= pwdata[mlm_pkg::WIN_W-1:0];
                end else begin
                    r_cc <= pwdata[mlm_pkg::CC_W-1:0];
                end
                r_pos   <= '0;
                r_frame <= '0;
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    r_acc[i] <= '0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_square <= mlm_pkg::SUM_W'($unsigned(w_prod));
        end
        if (r_state == mlm_pkg::S_ACC) begin
            r_total <= '0;
        end else if (r_state == mlm_pkg::S_SUM) begin
            r_total <= r_total + TW'(w_rms);
        end
        if ((r_state == mlm_pkg::S_OUT) && w_out_free) begin
            r_level <= w_unit_q[SAMPLE_BITS-2:0];
        end
    end

    // ---------------------------------------------------------------
    // Port outputs
    // ---------------------------------------------------------------
    assign o_valid = r_out_valid;
    assign o_level = r_level;
    assign pready  = 1'b1;

    always_comb begin
        if (paddr[mlm_pkg::ADDR_W-1] == mlm_pkg::REG_WINDOW_FRAMES) begin
            prdata = mlm_pkg::APB_W'(r_win);
        end else begin
            prdata = mlm_pkg::APB_W'(r_cc);
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `MLM_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_unit_done, (r_state == mlm_pkg::S_DIV_WAIT) || (r_state == mlm_pkg::S_SQRT_WAIT) || (r_state == mlm_pkg::S_MEAN_WAIT))
    `MLM_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1, CNT'(r_pos) < CNT'(w_chans))
    `MLM_ASSERT_NEXT(a_window_cleared, i_clk, i_rst_n, (r_state == mlm_pkg::S_OUT) && w_out_free, (r_pos == '0) && (r_frame == '0) && r_out_valid)

endmodule

### hw/rtl/mlm_divsqrt.sv
// Shared shift-and-subtract unit: restoring division (one quotient bit per
// cycle) or digit-by-digit square root (one root bit per cycle).
module mlm_divsqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mlm_pkg::t_unit_cmd        i_cmd,
    input  logic [mlm_pkg::SUM_W-1:0] i_x,
    input  logic [mlm_pkg::WIN_W-1:0] i_d,
    output logic                      o_done,
    output logic [mlm_pkg::SUM_W-1:0] o_q
);

    logic                        r_busy;
    logic                        r_done;
    logic [mlm_pkg::STEP_W-1:0]  r_cnt;
    mlm_pkg::t_op                r_op;
    logic [mlm_pkg::SUM_W-1:0]   r_x;
    logic [mlm_pkg::SUM_W-1:0]   r_q;
    logic [mlm_pkg::REM_W-1:0]   r_rem;
    logic [mlm_pkg::WIN_W-1:0]   r_d;

    logic [mlm_pkg::REM_W-1:0]   w_rem_sh;
    logic [mlm_pkg::REM_W-1:0]   w_trial;
    logic [mlm_pkg::REM_W:0]     w_diff;
    logic                        w_ge;

    // Bring down one dividend bit or two radicand bits, then try the subtract
    always_comb begin
        if (r_op == mlm_pkg::OP_SQRT) begin
            w_rem_sh = {r_rem[mlm_pkg::REM_W-3:0], r_x[mlm_pkg::SUM_W-1 -: 2]};
            w_trial  = {r_q[mlm_pkg::REM_W-3:0], 2'b01};
        end else begin
            w_rem_sh = {r_rem[mlm_pkg::REM_W-2:0], r_x[mlm_pkg::SUM_W-1]};
            w_trial  = mlm_pkg::REM_W'(r_d);
        end
        w_diff = {1'b0, w_rem_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[mlm_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_cmd.op == mlm_pkg::OP_SQRT) ?
                          mlm_pkg::STEP_W'(mlm_pkg::SQRT_STEPS) :
                          mlm_pkg::STEP_W'(mlm_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mlm_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_x   <= i_x;
            r_d   <= i_d;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[mlm_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[mlm_pkg::REM_W-1:0] : w_rem_sh;
            r_x   <= (r_op == mlm_pkg::OP_SQRT) ? (r_x << 2) : (r_x << 1);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int                 CHANNEL_LIMIT  = mlm_pkg::MAX_CHANNELS_DEF;
    localparam int                 RESET_CYCLES   = 12;
    // Quiet cycles after the last level before a register write: an item that
    // closes no window only needs its accumulate to finish.
    localparam int                 DRAIN_CYCLES   = 16;
    // Longest correct quiet stretch is the receiver hold-off or one window end
    // with eight channels; allow many times that.
    localparam int                 WATCHDOG_LIMIT = 20000;
    localparam int                 HOLD_OFF       = 1500;
    localparam int                 RANDOM_ITEMS   = 1300;
    localparam int                 RANDOM_LEVELS  = 60;
    localparam logic [63:0]        FULL_SCALE     = 64'd8388607;
    localparam logic signed [23:0] MOST_NEG       = 24'sh800000;
    localparam logic signed [23:0] MOST_POS       = 24'sh7FFFFF;

    // Clock, reset and every block input start at known values.
    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic signed [23:0]        i_sample = '0;
    logic                      i_ready = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [mlm_pkg::ADDR_W-1:0] paddr  = '0;
    logic [mlm_pkg::APB_W-1:0] pwdata  = '0;
    logic                      o_ready;
    logic                      o_valid;
    logic [22:0]               o_level;
    logic [mlm_pkg::APB_W-1:0] prdata;
    logic                      pready;

    // Predicted state of the meter: register copies and the open window.
    logic [3:0]                set_channels;
    logic [15:0]               set_window;
    logic [61:0]               channel_sums [CHANNEL_LIMIT];
    int                        next_channel;
    logic [15:0]               frames_done;
    logic [22:0]               expected_levels [$];

    // Items waiting for the driver, and progress counters.
    logic signed [23:0]        pending_samples [$];
    int                        items_pushed    = 0;
    int                        items_taken     = 0;
    int                        levels_checked  = 0;
    int                        settings_used   = 0;
    int                        mismatches      = 0;
    int                        quiet_cycles    = 0;
    int                        hold_left       = 0;
    logic                      stall_request   = 1'b0;
    logic                      stall_done      = 1'b0;
    logic                      calm;

    // Both sides stop idling for a stretch in the middle of the run.
    assign calm = (items_taken >= 600) && (items_taken < 800);

    always #5 i_clk = ~i_clk;

    multichannel_rms_level_meter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_level  (o_level),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Level predictor
    // ------------------------------------------------------------------

    // Clear the accumulators and both positions: a new window starts.
    function automatic void restart_window();
        foreach (channel_sums[c]) begin
            channel_sums[c] = '0;
        end
        next_channel = 0;
        frames_done  = '0;
    endfunction

    // Floor square root, two bits of the radicand per step.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > x) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Add one accepted item to its channel; on the item that closes the
    // window, queue the mean of the saturated channel RMS values.
    function automatic void meter_sample(input logic signed [23:0] s);
        int          chans;
        logic [63:0] win;
        longint      mag;
        logic [63:0] square;
        logic [63:0] rms;
        logic [63:0] total;
        chans = (set_channels == 0) ? 1 :
                (set_channels > CHANNEL_LIMIT) ? CHANNEL_LIMIT : int'(set_channels);
        win   = (set_window == 0) ? 64'd1 : 64'(set_window);
        mag   = (s < 0) ? -longint'(s) : longint'(s);
        square = 64'(mag * mag);
        // Sums wrap at their 62-bit width.
        channel_sums[next_channel] = channel_sums[next_channel] + square[61:0];
        next_channel++;
        if (next_channel < chans) begin
            return;
        end
        next_channel = 0;
        frames_done  = frames_done + 16'd1;
        if (64'(frames_done) < win) begin
            return;
        end
        total = '0;
        for (int c = 0; c < chans; c++) begin
            rms = root_floor(64'(channel_sums[c]) / win);
            // A channel of most negative samples lands one above full scale.
            if (rms > FULL_SCALE) begin
                rms = FULL_SCALE;
            end
            total = total + rms;
        end
        expected_levels.push_back(23'(total / 64'(chans)));
        restart_window();
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: offer the next pending item, hold it until taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
                i_valid  <= 1'b1;
                i_sample <= pending_samples.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, check every accepted level,
    // and drive the receiver ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            meter_sample(i_sample);
            items_taken++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_levels.size() == 0) begin
                $error("level %0d arrived with nothing expected", o_level);
                mismatches++;
            end else begin
                if (o_level !== expected_levels[0]) begin
                    $error("level mismatch: expected %0d, actual %0d",
                           expected_levels[0], o_level);
                    mismatches++;
                end
                void'(expected_levels.pop_front());
                levels_checked++;
            end
        end
        // One long hold-off: the output register fills, the next level is
        // computed and the block has to stall its input.
        if (stall_request && !stall_done) begin
            hold_left  = HOLD_OFF;
            stall_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_sample(input logic signed [23:0] s);
        pending_samples.push_back(s);
        items_pushed++;
    endtask

    // Mostly full-range noise, some quiet signal, some extremes.
    function automatic logic signed [23:0] random_sample();
        logic [31:0] r;
        int          kind;
        r    = $urandom();
        kind = $urandom_range(99);
        if (kind < 4) begin
            return MOST_NEG;
        end else if (kind < 8) begin
            return MOST_POS;
        end else if (kind < 10) begin
            return '0;
        end else if (kind < 35) begin
            return $signed(r[23:0]) >>> $urandom_range(22, 1);
        end
        return r[23:0];
    endfunction

    // Wait until every item is taken and every level checked, then drain.
    task automatic wait_idle();
        while (items_taken != items_pushed || expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, access cycle, done at the edge after.
    task automatic apb_access(input logic wr, input logic reg_index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic reg_index, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, reg_index, '0, got);
        if (got !== want) begin
            $error("register %0d readback mismatch: expected %0d, actual %0d",
                   reg_index, want, got);
            mismatches++;
        end
    endtask

    // Write both registers while idle; each write restarts the window.
    task automatic configure(input logic [3:0] chans, input logic [15:0] frames);
        logic [31:0] unused;
        wait_idle();
        apb_access(1'b1, mlm_pkg::REG_CHANNEL_COUNT, 32'(chans), unused);
        set_channels = chans;
        restart_window();
        apb_access(1'b1, mlm_pkg::REG_WINDOW_FRAMES, 32'(frames), unused);
        set_window = frames;
        restart_window();
        check_register(mlm_pkg::REG_CHANNEL_COUNT, 32'(chans));
        check_register(mlm_pkg::REG_WINDOW_FRAMES, 32'(frames));
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0]  chans;
        logic [15:0] frames;
        int          act_chans;
        int          act_frames;
        int          count;
        bit          loud;

        set_channels = mlm_pkg::CC_RESET;
        set_window   = mlm_pkg::WIN_RESET;
        restart_window();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers come out of reset at two channels, 512 frames.
        check_register(mlm_pkg::REG_CHANNEL_COUNT, 32'(mlm_pkg::CC_RESET));
        check_register(mlm_pkg::REG_WINDOW_FRAMES, 32'(mlm_pkg::WIN_RESET));

        // Stereo, one-frame windows: most negative in every position
        // saturates, full positive scale, and a mix of silence and overload.
        configure(4'd2, 16'd1);
        push_sample(MOST_NEG);
        push_sample(MOST_NEG);
        push_sample(MOST_POS);
        push_sample(MOST_POS);
        push_sample('0);
        push_sample(MOST_NEG);

        // Zero channel count and zero window length both act as one.
        configure(4'd0, 16'd0);
        push_sample(MOST_NEG);
        push_sample(24'sd1);
        push_sample(MOST_POS);

        // Channel count above the maximum saturates to eight channels.
        configure(4'd15, 16'd1);
        push_sample(MOST_POS);
        push_sample(MOST_NEG);
        push_sample('0);
        push_sample(-24'sd1);
        push_sample(24'sd1);
        push_sample(24'sd4096);
        push_sample(-24'sd4096);
        push_sample(MOST_POS);

        // Longest window: a partial frame is dropped by the next write.
        configure(4'd8, 16'd65535);
        push_sample(MOST_NEG);
        push_sample(MOST_POS);
        push_sample(24'sd12345);
        push_sample(-24'sd54321);

        // Mono over two frames: the mean square rounds down before the root.
        configure(4'd1, 16'd2);
        push_sample(24'sd3);
        push_sample('0);

        // Back-pressure: a level per item while the receiver holds off.
        configure(4'd1, 16'd1);
        stall_request = 1'b1;
        repeat (60) push_sample(random_sample());
        wait_idle();
        stall_request = 1'b0;

        // Random settings, one to three windows each plus a partial one that the next write drops.
        while (items_pushed < RANDOM_ITEMS || levels_checked < RANDOM_LEVELS) begin
            count = $urandom_range(99);
            if (count < 6) begin
                chans = 4'd0;
            end else if (count < 12) begin
                chans = 4'($urandom_range(15, 9));
            end else begin
                chans = 4'($urandom_range(8, 1));
            end
            count = $urandom_range(99);
            if (count < 5) begin
                frames = 16'd0;
            end else if (count < 75) begin
                frames = 16'($urandom_range(3, 1));
            end else if (count < 95) begin
                frames = 16'($urandom_range(12, 4));
            end else begin
                frames = 16'($urandom_range(40, 13));
            end
            configure(chans, frames);
            act_chans  = (chans == 0) ? 1 : (chans > CHANNEL_LIMIT) ? CHANNEL_LIMIT : chans;
            act_frames = (frames == 0) ? 1 : frames;
            count = act_chans * act_frames * $urandom_range(3, 1)
                  + $urandom_range(act_chans * act_frames - 1, 0);
            // Now and then a setting fed nothing but the most negative value.
            loud = ($urandom_range(9) == 0);
            repeat (count) push_sample(loud ? MOST_NEG : random_sample());
        end

        wait_idle();
        $display("run summary: %0d items metered, %0d levels checked, %0d settings",
                 items_taken, levels_checked, settings_used);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
